/* hdl/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, sizes and codes of the IP range stabbing lookup.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int V4_DEPTH    = 4096;
  localparam int V6_DEPTH    = 1024;
  localparam int MAX_MATCHES = 64;

  localparam int V4_AW = $clog2(V4_DEPTH);
  localparam int V6_AW = $clog2(V6_DEPTH);
  localparam int V4_CW = $clog2(V4_DEPTH + 1);
  localparam int V6_CW = $clog2(V6_DEPTH + 1);
  localparam int IW    = (V4_CW > V6_CW) ? V4_CW : V6_CW;
  localparam int NW    = $clog2(MAX_MATCHES + 1);

  localparam int V4_W = 3 * 32 + 16;
  localparam int V6_W = 3 * 128 + 16;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_WALK,
    ST_WCMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic s_rd;
    logic s_upd;
    logic w_init;
    logic w_rd;
    logic w_step;
    logic w_take;
    logic set_trunc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic start_le;
    logic i_zero;
    logic max_lt;
    logic end_ge;
    logic n_full;
    logic pend_v;
    logic out_free;
  } stat_t;

endpackage

/* hdl/isl_ram.sv */
// ----------------------------------------------------------------------------
// isl_ram
// Single-port RAM, one write and one registered read per cycle at one shared address.
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wr_data,
  output logic [W-1:0]         rd_data
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

/* hdl/isl_ctrl.sv */
// ----------------------------------------------------------------------------
// isl_ctrl
// Sequencer: accept, binary search, backward walk, final result.
// ----------------------------------------------------------------------------
module isl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_req_type,
  output logic           in_ready,
  input  isl_pkg::stat_t st,
  output isl_pkg::cmd_t  cmd
);
  import isl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type == REQ_QUERY) state_nxt = ST_SRCH;
      end
      ST_SRCH: state_nxt = st.lt ? ST_SCMP : ST_WALK;
      ST_SCMP: state_nxt = ST_SRCH;
      ST_WALK: state_nxt = st.i_zero ? ST_FIN : ST_WCMP;
      ST_WCMP: begin
        priority if (st.max_lt) state_nxt = ST_FIN;
        else if (st.end_ge && st.n_full) state_nxt = ST_FIN;
        else if (st.end_ge && st.pend_v && !st.out_free) state_nxt = ST_WCMP;
        else state_nxt = ST_WALK;
      end
      ST_FIN: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SRCH: begin
        cmd.s_rd = st.lt;
        cmd.w_init = !st.lt;
      end
      ST_SCMP: cmd.s_upd = 1'b1;
      ST_WALK: cmd.w_rd = !st.i_zero;
      ST_WCMP: begin
        priority if (st.max_lt) begin
        end else if (st.end_ge && st.n_full) begin
          cmd.set_trunc = 1'b1;
        end else if (st.end_ge) begin
          cmd.w_take = !st.pend_v || st.out_free;
        end else begin
          cmd.w_step = 1'b1;
        end
      end
      ST_FIN: cmd.fin = st.out_free;
      default: begin
      end
    endcase
  end
endmodule

/* hdl/isl_dp.sv */
// ----------------------------------------------------------------------------
// isl_dp
// Tables, search and walk registers, pending match and output register.
// ----------------------------------------------------------------------------
module isl_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  isl_pkg::cmd_t  cmd,
  output isl_pkg::stat_t st,
  input  logic [1:0]     in_req_type,
  input  logic           in_family,
  input  logic [63:0]    in_key_hi,
  input  logic [63:0]    in_key_lo,
  input  logic [63:0]    in_end_hi,
  input  logic [63:0]    in_end_lo,
  input  logic [15:0]    in_tag,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_found,
  output logic [15:0]    out_match_tag,
  output logic [63:0]    out_match_start_hi,
  output logic [63:0]    out_match_start_lo,
  output logic [63:0]    out_match_end_hi,
  output logic [63:0]    out_match_end_lo,
  output logic           out_truncated,
  output logic           out_last
);
  import isl_pkg::*;

  logic [V4_CW-1:0] v4_cnt_r;
  logic [V6_CW-1:0] v6_cnt_r;
  logic [31:0]      v4_last_max_r;
  logic [127:0]     v6_last_max_r;
  logic [127:0]     key_r;
  logic             fam_r;
  logic [IW-1:0]    lo_r, hi_r, i_r;
  logic [NW-1:0]    n_r;
  logic             trunc_r;
  logic             pend_v_r;
  logic [15:0]      pend_tag_r;
  logic [127:0]     pend_start_r, pend_end_r;
  logic             out_valid_r, out_found_r, out_trunc_r, out_last_r;
  logic [15:0]      out_tag_r;
  logic [127:0]     out_start_r, out_end_r;

  logic [IW-1:0]    mid, idx;
  logic             load, v4_wr, v6_wr;
  logic [31:0]      v4_max_w;
  logic [127:0]     v6_end_w, v6_max_w;
  logic [V4_W-1:0]  v4_rd;
  logic [V6_W-1:0]  v6_rd;
  logic [127:0]     e_start, e_end, e_max;
  logic [15:0]      e_tag;
  logic             out_free;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign idx = cmd.s_rd ? mid : (i_r - IW'(1));

  assign load  = cmd.accept && in_req_type == REQ_LOAD;
  assign v4_wr = load && !in_family && v4_cnt_r != V4_CW'(V4_DEPTH);
  assign v6_wr = load && in_family && v6_cnt_r != V6_CW'(V6_DEPTH);

  assign v4_max_w = (v4_cnt_r == '0 || in_end_lo[31:0] > v4_last_max_r)
                    ? in_end_lo[31:0] : v4_last_max_r;
  assign v6_end_w = {in_end_hi, in_end_lo};
  assign v6_max_w = (v6_cnt_r == '0 || v6_end_w > v6_last_max_r)
                    ? v6_end_w : v6_last_max_r;

  isl_ram #(.W(V4_W), .D(V4_DEPTH)) u_v4_ram (
    .clk     (clk),
    .wr_en   (v4_wr),
    .rd_en   ((cmd.s_rd || cmd.w_rd) && !fam_r),
    .addr    (v4_wr ? v4_cnt_r[V4_AW-1:0] : idx[V4_AW-1:0]),
    .wr_data ({in_tag, v4_max_w, in_end_lo[31:0], in_key_lo[31:0]}),
    .rd_data (v4_rd)
  );

  isl_ram #(.W(V6_W), .D(V6_DEPTH)) u_v6_ram (
    .clk     (clk),
    .wr_en   (v6_wr),
    .rd_en   ((cmd.s_rd || cmd.w_rd) && fam_r),
    .addr    (v6_wr ? v6_cnt_r[V6_AW-1:0] : idx[V6_AW-1:0]),
    .wr_data ({in_tag, v6_max_w, v6_end_w, in_key_hi, in_key_lo}),
    .rd_data (v6_rd)
  );

  always_comb begin
    if (fam_r) begin
      e_start = v6_rd[127:0];
      e_end   = v6_rd[255:128];
      e_max   = v6_rd[383:256];
      e_tag   = v6_rd[399:384];
    end else begin
      e_start = {96'd0, v4_rd[31:0]};
      e_end   = {96'd0, v4_rd[63:32]};
      e_max   = {96'd0, v4_rd[95:64]};
      e_tag   = v4_rd[111:96];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign st.lt       = lo_r < hi_r;
  assign st.start_le = e_start <= key_r;
  assign st.i_zero   = i_r == '0;
  assign st.max_lt   = e_max < key_r;
  assign st.end_ge   = e_end >= key_r;
  assign st.n_full   = n_r == NW'(MAX_MATCHES);
  assign st.pend_v   = pend_v_r;
  assign st.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_cnt_r    <= '0;
      v6_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (v4_wr) begin
        v4_cnt_r      <= v4_cnt_r + V4_CW'(1);
        v4_last_max_r <= v4_max_w;
      end
      if (v6_wr) begin
        v6_cnt_r      <= v6_cnt_r + V6_CW'(1);
        v6_last_max_r <= v6_max_w;
      end
      if (cmd.accept && in_req_type == REQ_CLEAR) begin
        v4_cnt_r <= '0;
        v6_cnt_r <= '0;
      end
      if (cmd.accept && in_req_type == REQ_QUERY) begin
        fam_r    <= in_family;
        key_r    <= in_family ? {in_key_hi, in_key_lo} : {96'd0, in_key_lo[31:0]};
        lo_r     <= '0;
        hi_r     <= in_family ? IW'(v6_cnt_r) : IW'(v4_cnt_r);
        n_r      <= '0;
        trunc_r  <= 1'b0;
        pend_v_r <= 1'b0;
      end
      if (cmd.s_upd) begin
        if (st.start_le) lo_r <= mid + IW'(1);
        else hi_r <= mid;
      end
      if (cmd.w_init) i_r <= lo_r;
      if (cmd.w_step) i_r <= i_r - IW'(1);
      if (cmd.set_trunc) trunc_r <= 1'b1;

      if ((cmd.w_take && pend_v_r) || cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.w_take) begin
        i_r          <= i_r - IW'(1);
        n_r          <= n_r + NW'(1);
        pend_v_r     <= 1'b1;
        pend_tag_r   <= e_tag;
        pend_start_r <= e_start;
        pend_end_r   <= e_end;
        if (pend_v_r) begin
          out_found_r <= 1'b1;
          out_tag_r   <= pend_tag_r;
          out_start_r <= pend_start_r;
          out_end_r   <= pend_end_r;
          out_trunc_r <= 1'b0;
          out_last_r  <= 1'b0;
        end
      end
      if (cmd.fin) begin
        out_found_r <= pend_v_r;
        out_tag_r   <= pend_v_r ? pend_tag_r : 16'd0;
        out_start_r <= pend_v_r ? pend_start_r : 128'd0;
        out_end_r   <= pend_v_r ? pend_end_r : 128'd0;
        out_trunc_r <= pend_v_r && trunc_r;
        out_last_r  <= 1'b1;
        pend_v_r    <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_tag      = out_tag_r;
  assign out_match_start_hi = out_start_r[127:64];
  assign out_match_start_lo = out_start_r[63:0];
  assign out_match_end_hi   = out_end_r[127:64];
  assign out_match_end_lo   = out_end_r[63:0];
  assign out_truncated      = out_trunc_r;
  assign out_last           = out_last_r;
endmodule

/* hdl/ip_range_stabbing_lookup_core.sv */
// ----------------------------------------------------------------------------
// ip_range_stabbing_lookup_core
// IPv4/IPv6 range tables with stabbing queries over sorted starts.
// ----------------------------------------------------------------------------
// Loads and clears are carried out as they are accepted. An accepted query
// runs a binary search, each step reading the middle entry and then comparing
// it (at most floor(log2 n)+1 steps over the n loaded entries, none when the
// table is empty), starts the walk at the search result, walks backward
// reading and then comparing each entry until it reaches index zero or ends,
// and ends with the final result; every table access goes through the single
// registered-read port of that table's RAM, and a full output register stalls
// the walk and the final result. One query is in work at a time.
module ip_range_stabbing_lookup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_family,
  input  logic [63:0] in_key_hi,
  input  logic [63:0] in_key_lo,
  input  logic [63:0] in_end_hi,
  input  logic [63:0] in_end_lo,
  input  logic [15:0] in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_match_tag,
  output logic [63:0] out_match_start_hi,
  output logic [63:0] out_match_start_lo,
  output logic [63:0] out_match_end_hi,
  output logic [63:0] out_match_end_lo,
  output logic        out_truncated,
  output logic        out_last
);
  import isl_pkg::*;

  cmd_t  cmd;
  stat_t st;

  isl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .st          (st),
    .cmd         (cmd)
  );

  isl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_req_type        (in_req_type),
    .in_family          (in_family),
    .in_key_hi          (in_key_hi),
    .in_key_lo          (in_key_lo),
    .in_end_hi          (in_end_hi),
    .in_end_lo          (in_end_lo),
    .in_tag             (in_tag),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_match_tag      (out_match_tag),
    .out_match_start_hi (out_match_start_hi),
    .out_match_start_lo (out_match_start_lo),
    .out_match_end_hi   (out_match_end_hi),
    .out_match_end_lo   (out_match_end_lo),
    .out_truncated      (out_truncated),
    .out_last           (out_last)
  );
endmodule

/* hdl/isl_checker.sv */
// ----------------------------------------------------------------------------
// isl_checker
// Port-level checks of the result channel.
// ----------------------------------------------------------------------------
module isl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [15:0] out_match_tag,
  input logic        out_truncated,
  input logic        out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_match_tag) && $stable(out_last))
    else $error("stalled result changed");

  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_match_tag == 16'd0)
    else $error("no-match result malformed");

  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last && out_found)
    else $error("truncated off final match");
endmodule

bind ip_range_stabbing_lookup_core isl_checker u_isl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_found     (out_found),
  .out_match_tag (out_match_tag),
  .out_truncated (out_truncated),
  .out_last      (out_last)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks ip_range_stabbing_lookup_core against a behavioral table model.
// Sends loads, queries, clears and unused codes through the valid/ready
// handshake, predicts every match item and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import isl_pkg::*;

  typedef struct {
    logic        found;
    logic [15:0] tag;
    logic [63:0] sh, sl, eh, el;
    logic        trunc, last;
  } match_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_req_type;
  logic        in_family;
  logic [63:0] in_key_hi, in_key_lo, in_end_hi, in_end_lo;
  logic [15:0] in_tag;
  logic        out_valid, out_ready, out_found, out_truncated, out_last;
  logic [15:0] out_match_tag;
  logic [63:0] out_match_start_hi, out_match_start_lo, out_match_end_hi, out_match_end_lo;

  ip_range_stabbing_lookup_core u_top (.*);

  logic [127:0] v4s [V4_DEPTH], v4e [V4_DEPTH], v4m [V4_DEPTH];
  logic [127:0] v6s [V6_DEPTH], v6e [V6_DEPTH], v6m [V6_DEPTH];
  logic [15:0]  v4t [V4_DEPTH], v6t [V6_DEPTH];
  int           v4n, v6n;
  match_t       pending_matches[$];
  int           errors;
  int           cycles;
  bit           quiet;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors < 50) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic predict_request(input logic [1:0] rt, input logic fam,
                                 input logic [127:0] key, input logic [127:0] e,
                                 input logic [15:0] tg);
    int lo, hi, mid, j, nm, cnt;
    bit tr;
    logic [127:0] a, m;
    match_t r;
    if (rt == REQ_CLEAR) begin
      v4n = 0; v6n = 0;
    end else if (rt == REQ_LOAD) begin
      if (!fam) begin
        if (v4n < V4_DEPTH) begin
          m = {96'd0, e[31:0]};
          if (v4n > 0 && v4m[v4n-1] > m) m = v4m[v4n-1];
          v4s[v4n] = {96'd0, key[31:0]}; v4e[v4n] = {96'd0, e[31:0]};
          v4m[v4n] = m; v4t[v4n] = tg;
          v4n++;
        end
      end else if (v6n < V6_DEPTH) begin
        m = e;
        if (v6n > 0 && v6m[v6n-1] > m) m = v6m[v6n-1];
        v6s[v6n] = key; v6e[v6n] = e; v6m[v6n] = m; v6t[v6n] = tg;
        v6n++;
      end
    end else if (rt == REQ_QUERY) begin
      a = fam ? key : {96'd0, key[31:0]};
      cnt = fam ? v6n : v4n;
      lo = 0; hi = cnt; nm = 0; tr = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ((fam ? v6s[mid] : v4s[mid]) <= a) lo = mid + 1; else hi = mid;
      end
      for (j = lo - 1; j >= 0; j--) begin
        if ((fam ? v6m[j] : v4m[j]) < a) break;
        if ((fam ? v6e[j] : v4e[j]) >= a) begin
          if (nm >= MAX_MATCHES) begin
            tr = 1;
            break;
          end
          r.found = 1; r.tag = fam ? v6t[j] : v4t[j];
          {r.sh, r.sl} = fam ? v6s[j] : v4s[j];
          {r.eh, r.el} = fam ? v6e[j] : v4e[j];
          r.trunc = 0; r.last = 0;
          pending_matches = {pending_matches, r};
          nm++;
        end
      end
      if (nm == 0) begin
        r = '{0, 0, 0, 0, 0, 0, 0, 1};
        pending_matches = {pending_matches, r};
      end else begin
        pending_matches[$].trunc = tr;
        pending_matches[$].last = 1;
      end
    end
  endtask

  always @(posedge clk) begin
    match_t x;
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) report("unexpected result");
      else begin
        x = pending_matches.pop_front();
        if (out_found !== x.found) report("found");
        if (out_match_tag !== x.tag) report("match_tag");
        if (out_match_start_hi !== x.sh) report("match_start_hi");
        if (out_match_start_lo !== x.sl) report("match_start_lo");
        if (out_match_end_hi !== x.eh) report("match_end_hi");
        if (out_match_end_lo !== x.el) report("match_end_lo");
        if (out_truncated !== x.trunc) report("truncated");
        if (out_last !== x.last) report("last");
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
  end

  task automatic send_request(input logic [1:0] rt, input logic fam,
                              input logic [127:0] key, input logic [127:0] e,
                              input logic [15:0] tg);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_req_type <= rt; in_family <= fam;
    {in_key_hi, in_key_lo} <= key; {in_end_hi, in_end_lo} <= e; in_tag <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(rt, fam, key, e, tg);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  function automatic logic [127:0] rnd128;
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_directed;
    send_request(REQ_QUERY, 0, 0, 0, 0);
    send_request(REQ_QUERY, 1, '1, 0, 0);
    send_request(REQ_LOAD, 0, {96'hFFFF, 32'd10}, {96'hABC, 32'd20}, 16'hFFFF);
    send_request(REQ_LOAD, 0, 128'd15, 128'hFFFF_FFFF, 16'h0001);
    send_request(REQ_LOAD, 0, 128'd30, 128'd31, 16'h0002);
    send_request(REQ_QUERY, 0, {96'h1234, 32'd16}, 0, 0);
    send_request(REQ_QUERY, 0, 128'd5, 0, 0);
    send_request(REQ_QUERY, 0, 128'hFFFF_FFFF, 0, 0);
    send_request(REQ_LOAD, 0, 128'd3, 128'd40, 16'h0003);
    send_request(REQ_QUERY, 0, 128'd35, 0, 0);
    send_request(REQ_LOAD, 1, 0, '1, 16'h8000);
    send_request(REQ_LOAD, 1, {64'd1, 64'd0}, {64'd1, 64'd5}, 16'h4000);
    send_request(REQ_QUERY, 1, {64'd1, 64'd3}, 0, 0);
    send_request(REQ_QUERY, 1, '1, 0, 0);
    send_request(REQ_UNUSED, 1, 0, 0, 0);
    send_request(REQ_CLEAR, 0, 0, 0, 0);
    send_request(REQ_QUERY, 0, 128'd16, 0, 0);
    drain();
  endtask

  task automatic test_match_limit;
    for (int i = 0; i < MAX_MATCHES + 3; i++)
      send_request(REQ_LOAD, 1, 128'(i), '1, 16'(i));
    send_request(REQ_QUERY, 1, 128'd200, 0, 0);
    send_request(REQ_QUERY, 1, 128'd10, 0, 0);
    send_request(REQ_QUERY, 1, 128'(MAX_MATCHES - 1), 0, 0);
    drain();
    send_request(REQ_CLEAR, 1, 0, 0, 0);
  endtask

  task automatic test_random;
    logic [127:0] k, e;
    logic fam;
    int r;
    for (int it = 0; it < 60; it++) begin
      quiet = (it >= 20 && it < 40);
      fam = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 50) begin
        k = fam ? (rnd128() >> $urandom_range(120))
                : ((rnd128() & ~128'hFFFF_FFFF) | 128'($urandom_range(1000)));
        if ($urandom_range(9) == 0) k = rnd128();
        e = k + 128'($urandom_range(300));
        if ($urandom_range(9) == 0) e = rnd128();
        send_request(REQ_LOAD, fam, k, e, 16'($urandom));
      end else if (r < 95) begin
        k = fam ? (rnd128() >> $urandom_range(120))
                : ((rnd128() & ~128'hFFFF_FFFF) | 128'($urandom_range(1300)));
        if ($urandom_range(7) == 0) k = rnd128();
        send_request(REQ_QUERY, fam, k, rnd128(), 16'($urandom));
      end else if (r < 98) begin
        send_request(REQ_CLEAR, fam, rnd128(), rnd128(), 16'($urandom));
      end else begin
        send_request(REQ_UNUSED, fam, rnd128(), rnd128(), 16'($urandom));
      end
      if (it == 45) drain();
    end
    quiet = 0;
    drain();
  endtask

  initial begin
    errors = 0; cycles = 0; quiet = 0; v4n = 0; v6n = 0;
    rst_n = 0; in_valid = 0; in_req_type = REQ_LOAD; in_family = 0;
    in_key_hi = 0; in_key_lo = 0; in_end_hi = 0; in_end_lo = 0; in_tag = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_match_limit();
    test_random();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_matches.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* filelist.f */
hdl/isl_pkg.sv
hdl/isl_ram.sv
hdl/isl_ctrl.sv
hdl/isl_dp.sv
hdl/ip_range_stabbing_lookup_core.sv
hdl/isl_checker.sv
tb/testbench.sv
